// ===== sv/imu_dbi_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_dbi_pkg
// Shared types and constants of the IMU decimator with bias removal and IIR.
// ----------------------------------------------------------------------------
package imu_dbi_pkg;

	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_PROCESS = 1'b1;

	typedef enum logic [2:0] {
		CFG_GYRO_BIAS_X   = 3'd0,
		CFG_GYRO_BIAS_Y   = 3'd1,
		CFG_GYRO_BIAS_Z   = 3'd2,
		CFG_GYRO_FS       = 3'd3,
		CFG_ACCEL_FS      = 3'd4
	} cfg_idx_t;

	localparam logic [11:0] GYRO_FS_RESET  = 12'd2000;
	localparam logic [6:0]  ACCEL_FS_RESET = 7'd16;

	// y = (COEF_OLD*y + COEF_NEW*x + ROUND_HALF) >> 16
	localparam logic signed [16:0] COEF_NEW   = 17'sd62259;
	localparam logic signed [16:0] COEF_OLD   = 17'sd3277;
	localparam logic signed [48:0] ROUND_HALF = 49'sd32768;

	// 25 degrees in Q16.16
	localparam logic signed [31:0] TEMP_OFFSET = 32'sd1638400;

	typedef struct packed {
		logic              cmd;
		logic signed [15:0] temp_raw;
		logic signed [15:0] gyro_x_raw;
		logic signed [15:0] gyro_y_raw;
		logic signed [15:0] gyro_z_raw;
		logic signed [15:0] accel_x_raw;
		logic signed [15:0] accel_y_raw;
		logic signed [15:0] accel_z_raw;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] gyro_x_filt;
		logic signed [31:0] gyro_y_filt;
		logic signed [31:0] gyro_z_filt;
		logic signed [31:0] accel_x_filt;
		logic signed [31:0] accel_y_filt;
		logic signed [31:0] accel_z_filt;
		logic signed [31:0] temp_celsius;
		logic              overrun;
	} out_item_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic dropped;
	} front_status_t;

endpackage

// ===== sv/imu_dbi_front.sv =====
// ----------------------------------------------------------------------------
// imu_dbi_front
// Accumulates raw samples and hands a snapshot of a period to the queue.
// ----------------------------------------------------------------------------
module imu_dbi_front #(
	parameter int MAX_SAMPLES = 64,
	parameter int SW = 23,
	parameter int CW = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  imu_dbi_pkg::in_item_t   sample,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [7*SW+CW:0]        q_data,
	output imu_dbi_pkg::front_status_t status
);

	logic signed [SW-1:0] sum_q [7];
	logic signed [15:0]   raw [7];
	logic [CW-1:0]        count_q;
	logic                 dropped_q;
	logic                 accept;
	logic                 is_full;

	assign raw[0] = sample.temp_raw;
	assign raw[1] = sample.gyro_x_raw;
	assign raw[2] = sample.gyro_y_raw;
	assign raw[3] = sample.gyro_z_raw;
	assign raw[4] = sample.accel_x_raw;
	assign raw[5] = sample.accel_y_raw;
	assign raw[6] = sample.accel_z_raw;

	assign sample_stall = (sample.cmd == imu_dbi_pkg::CMD_PROCESS) && q_full;
	assign accept       = sample_valid && !sample_stall;
	assign is_full      = (count_q == CW'(MAX_SAMPLES));
	assign q_push       = accept && (sample.cmd == imu_dbi_pkg::CMD_PROCESS) && (count_q != '0);

	always_comb begin
		q_data = '0;
		for (int i = 0; i < 7; i++) begin
			q_data[i*SW +: SW] = sum_q[i];
		end
		q_data[7*SW +: CW] = count_q;
		q_data[7*SW+CW]    = dropped_q;
	end

	assign status = '{full: is_full, empty: (count_q == '0), dropped: dropped_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 7; i++) begin
				sum_q[i] <= '0;
			end
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (q_push) begin
			for (int i = 0; i < 7; i++) begin
				sum_q[i] <= '0;
			end
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (accept && sample.cmd == imu_dbi_pkg::CMD_SAMPLE) begin
			if (is_full) begin
				dropped_q <= 1'b1;
			end else begin
				for (int i = 0; i < 7; i++) begin
					sum_q[i] <= sum_q[i] + {{(SW-16){raw[i][15]}}, raw[i]};
				end
				count_q <= count_q + CW'(1);
			end
		end
	end

endmodule

// ===== sv/imu_dbi_fifo.sv =====
// ----------------------------------------------------------------------------
// imu_dbi_fifo
// Two-entry queue of period snapshots between front and back.
// ----------------------------------------------------------------------------
module imu_dbi_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign rdata = mem_q[rd_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sv/imu_dbi_back.sv =====
// ----------------------------------------------------------------------------
// imu_dbi_back
// Divides, scales, removes bias and filters one snapshot, then emits it.
// ----------------------------------------------------------------------------
module imu_dbi_back #(
	parameter int SW = 23,
	parameter int CW = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  logic [7*SW+CW:0]               q_data,
	output logic                           q_pop,
	input  logic signed [2:0][31:0]        gyro_bias,
	input  logic [11:0]                    gyro_fs,
	input  logic [6:0]                     accel_fs,
	output logic                           result_valid,
	input  logic                           result_stall,
	output imu_dbi_pkg::out_item_t         result
);

	localparam int BW = $clog2(SW);

	typedef enum logic [2:0] {
		S_IDLE, S_START, S_DIV, S_MUL, S_FILT, S_EMIT
	} state_t;

	state_t               state_q;
	logic signed [SW-1:0] sums_q [7];
	logic [CW-1:0]        cnt_q;
	logic                 drop_q;
	logic [2:0]           ch_q;
	logic [CW-1:0]        rem_q;
	logic [SW-1:0]        quot_q;
	logic [BW-1:0]        bit_q;
	logic                 neg_q;
	logic signed [31:0]   temp_q;
	logic signed [31:0]   scaled_q;
	logic signed [31:0]   filt_q [6];

	logic [2:0]           ch_m1;
	logic [CW:0]          trial;
	logic                 ge;
	logic signed [16:0]   avg;
	logic [11:0]          fs;
	logic signed [29:0]   prod;
	logic signed [31:0]   bias;
	logic signed [33:0]   diff;
	logic signed [48:0]   acc;
	logic signed [31:0]   sat_scaled;
	logic signed [31:0]   sat_filt;
	logic signed [SW-1:0] cur_sum;

	assign ch_m1   = ch_q - 3'd1;
	assign cur_sum = sums_q[ch_q];
	assign trial   = {rem_q, quot_q[SW-1]};
	assign ge      = (trial >= {1'b0, cnt_q});
	assign avg     = neg_q ? -$signed({1'b0, quot_q[15:0]}) : $signed({1'b0, quot_q[15:0]});
	assign fs      = (ch_q <= 3'd3) ? gyro_fs : {5'd0, accel_fs};
	assign prod    = avg * $signed({1'b0, fs});
	assign bias    = (ch_q <= 3'd3) ? gyro_bias[ch_m1[1:0]] : 32'sd0;
	assign diff    = {{3{prod[29]}}, prod, 1'b0} - {{2{bias[31]}}, bias};
	assign acc     = filt_q[ch_m1] * imu_dbi_pkg::COEF_OLD
	               + scaled_q * imu_dbi_pkg::COEF_NEW + imu_dbi_pkg::ROUND_HALF;

	always_comb begin
		if (diff[33:31] == 3'b000 || diff[33:31] == 3'b111) begin
			sat_scaled = diff[31:0];
		end else begin
			sat_scaled = diff[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		if (acc[48:47] == 2'b00 || acc[48:47] == 2'b11) begin
			sat_filt = acc[47:16];
		end else begin
			sat_filt = acc[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	assign q_pop = (state_q == S_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				filt_q[i] <= '0;
			end
		end else begin
			// the emit step reloads the output itself when the old one leaves
			if (result_valid && !result_stall && state_q != S_EMIT) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						for (int i = 0; i < 7; i++) begin
							sums_q[i] <= q_data[i*SW +: SW];
						end
						cnt_q   <= q_data[7*SW +: CW];
						drop_q  <= q_data[7*SW+CW];
						ch_q    <= 3'd0;
						state_q <= S_START;
					end
				end
				S_START: begin
					neg_q   <= cur_sum[SW-1];
					quot_q  <= cur_sum[SW-1] ? -cur_sum : cur_sum;
					rem_q   <= '0;
					bit_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= ge ? CW'(trial - {1'b0, cnt_q}) : trial[CW-1:0];
					quot_q <= {quot_q[SW-2:0], ge};
					bit_q  <= bit_q + BW'(1);
					if (bit_q == BW'(SW-1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (ch_q == 3'd0) begin
						temp_q  <= imu_dbi_pkg::TEMP_OFFSET + {{7{avg[16]}}, avg, 8'd0};
						ch_q    <= 3'd1;
						state_q <= S_START;
					end else begin
						scaled_q <= sat_scaled;
						state_q  <= S_FILT;
					end
				end
				S_FILT: begin
					filt_q[ch_m1] <= sat_filt;
					if (ch_q == 3'd6) begin
						state_q <= S_EMIT;
					end else begin
						ch_q    <= ch_q + 3'd1;
						state_q <= S_START;
					end
				end
				S_EMIT: begin
					if (!result_valid || !result_stall) begin
						result.gyro_x_filt  <= filt_q[0];
						result.gyro_y_filt  <= filt_q[1];
						result.gyro_z_filt  <= filt_q[2];
						result.accel_x_filt <= filt_q[3];
						result.accel_y_filt <= filt_q[4];
						result.accel_z_filt <= filt_q[5];
						result.temp_celsius <= temp_q;
						result.overrun      <= drop_q;
						result_valid        <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/imu_decimate_bias_iir.sv =====
// ----------------------------------------------------------------------------
// imu_decimate_bias_iir
// Boxcar decimator for IMU samples with gyro bias removal and IIR smoothing.
// ----------------------------------------------------------------------------
// Use: drive sample items on sample/sample_valid; a transfer happens when
// sample_valid is high and sample_stall is low. A sample item (cmd 0) is
// taken and added into seven accumulators; past MAX_SAMPLES samples are
// dropped and the overrun flag is set. A process item (cmd 1) with a
// nonzero count hands a snapshot of the period to a two-entry queue and
// clears the accumulators in the same cycle, so sampling continues while
// the back end works. sample_stall rises only for a process item while
// the queue is full.
// The back end takes one snapshot at a time: per channel a one-bit-a-cycle
// restoring divider on SW-bit sums (SW = 17 + clog2(MAX_SAMPLES)), then
// scale and filter steps; the temperature channel is not filtered.
// The result sits in an output register; while result_stall is high it
// holds and the back end waits in its emit step.
// Reset clears accumulators, count, overrun flag, filter state and the queue;
// biases go to zero and full scales to 2000 dps and 16 g. Configuration
// writes (cfg_ready is always high) are the user's to keep to idle; unchecked.
// ----------------------------------------------------------------------------
module imu_decimate_bias_iir #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  imu_dbi_pkg::in_item_t     sample,
	output logic                      result_valid,
	input  logic                      result_stall,
	output imu_dbi_pkg::out_item_t    result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [31:0]               cfg_data
);

	localparam int SW = 17 + $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int QW = 7 * SW + CW + 1;

	logic signed [2:0][31:0]     gyro_bias_q;
	logic [11:0]                 gyro_fs_q;
	logic [6:0]                  accel_fs_q;

	logic                        q_push;
	logic                        q_pop;
	logic                        q_full;
	logic                        q_empty;
	logic [QW-1:0]               q_wdata;
	logic [QW-1:0]               q_rdata;
	imu_dbi_pkg::front_status_t  front_st;
	logic                        in_xfer;

	assign cfg_ready = 1'b1;
	assign in_xfer   = sample_valid && !sample_stall;

	// Register file: take a write on every handshake, drop unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_bias_q <= '0;
			gyro_fs_q   <= imu_dbi_pkg::GYRO_FS_RESET;
			accel_fs_q  <= imu_dbi_pkg::ACCEL_FS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (imu_dbi_pkg::cfg_idx_t'(cfg_index))
				imu_dbi_pkg::CFG_GYRO_BIAS_X: gyro_bias_q[0] <= cfg_data;
				imu_dbi_pkg::CFG_GYRO_BIAS_Y: gyro_bias_q[1] <= cfg_data;
				imu_dbi_pkg::CFG_GYRO_BIAS_Z: gyro_bias_q[2] <= cfg_data;
				imu_dbi_pkg::CFG_GYRO_FS:     gyro_fs_q      <= cfg_data[11:0];
				imu_dbi_pkg::CFG_ACCEL_FS:    accel_fs_q     <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Front: accumulate samples, close a period on a process item.
	imu_dbi_front #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SW          (SW),
		.CW          (CW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata),
		.status       (front_st)
	);

	// Queue of closed periods awaiting the back end.
	imu_dbi_fifo #(
		.W (QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: divide, scale, remove bias, filter and emit.
	imu_dbi_back #(
		.SW (SW),
		.CW (CW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.gyro_bias    (gyro_bias_q),
		.gyro_fs      (gyro_fs_q),
		.accel_fs     (accel_fs_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("snapshot pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("snapshot popped from an empty queue");

	a_drop_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && sample.cmd == imu_dbi_pkg::CMD_SAMPLE && front_st.full)
		|=> front_st.dropped)
		else $error("sample dropped without setting overrun");

	a_process_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && sample.cmd == imu_dbi_pkg::CMD_PROCESS && !front_st.empty)
		|=> (front_st.empty && !front_st.dropped))
		else $error("period not cleared after process transfer");

endmodule
